@@ rtl/srbf_pkg.sv @@
// Shared widths, types, register codes and reciprocal constants for the star record box filter.
package srbf_pkg;

  // Field widths
  localparam int unsigned RA_W     = 29;
  localparam int unsigned DEC_W    = 28;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned CMAG_W   = 18;
  localparam int unsigned ERR_W    = 24;
  localparam int unsigned DATE_W   = 32;
  localparam int unsigned HK_W     = 2 * MAG_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 29;

  // Result split widths
  localparam int unsigned HOURS_W  = 5;
  localparam int unsigned RMIN_W   = 6;
  localparam int unsigned RCS_W    = 13;
  localparam int unsigned DEG_W    = 8;
  localparam int unsigned DMIN_W   = 7;
  localparam int unsigned DSEC_W   = 11;

  // Pipeline depth: input register through result register
  localparam int unsigned NSTG     = 6;

  // Register reset values
  localparam logic [RA_W-1:0]           RA_LOW_RST   = RA_W'(0);
  localparam logic [RA_W-1:0]           RA_HIGH_RST  = RA_W'(360000000);
  localparam logic signed [DEC_W-1:0]   DEC_LOW_RST  = -DEC_W'(90000000);
  localparam logic signed [DEC_W-1:0]   DEC_HIGH_RST = DEC_W'(90000000);
  localparam logic signed [CMAG_W-1:0]  MAG_LOW_RST  = -CMAG_W'(99990);
  localparam logic signed [CMAG_W-1:0]  MAG_HIGH_RST = CMAG_W'(99990);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RA_LOW     = 3'd0,
    CFG_RA_HIGH    = 3'd1,
    CFG_WRAPS_ZERO = 3'd2,
    CFG_DEC_LOW    = 3'd3,
    CFG_DEC_HIGH   = 3'd4,
    CFG_MAG_LOW    = 3'd5,
    CFG_MAG_HIGH   = 3'd6
  } cfg_idx_e;

  // Window configuration
  typedef struct packed {
    logic [RA_W-1:0]          ra_low;
    logic [RA_W-1:0]          ra_high;
    logic                     wraps_zero;
    logic signed [DEC_W-1:0]  dec_low;
    logic signed [DEC_W-1:0]  dec_high;
    logic signed [CMAG_W-1:0] mag_low;
    logic signed [CMAG_W-1:0] mag_high;
  } cfg_t;

  // One star record as it travels the pipeline
  typedef struct packed {
    logic [RA_W-1:0]   ra;
    logic [DEC_W-1:0]  dec;
    logic [MAG_W-1:0]  j_mag;
    logic [MAG_W-1:0]  h_mag;
    logic [MAG_W-1:0]  k_mag;
    logic [ERR_W-1:0]  errors;
    logic [DATE_W-1:0] date;
  } rec_t;

  // Total RA centiseconds: floor(3 * ra / 125), 3 * ra below 2^31
  localparam int unsigned     CS_X_W = 31;
  localparam longint unsigned CS_DIV = 125;
  localparam int unsigned     CS_SH  = 38;
  localparam int unsigned     CS_M_W = 32;
  localparam logic [CS_M_W-1:0] CS_M =
    CS_M_W'(((64'd1 << CS_SH) + CS_DIV - 64'd1) / CS_DIV);
  localparam int unsigned     CS_P_W = CS_X_W + CS_M_W;
  localparam int unsigned     U_W    = 24;

  // Total declination deciseconds: floor(9 * |dec| / 250), 9 * |dec| below 2^31
  localparam int unsigned     DS_X_W = 31;
  localparam longint unsigned DS_DIV = 250;
  localparam int unsigned     DS_SH  = 39;
  localparam int unsigned     DS_M_W = 32;
  localparam logic [DS_M_W-1:0] DS_M =
    DS_M_W'(((64'd1 << DS_SH) + DS_DIV - 64'd1) / DS_DIV);
  localparam int unsigned     DS_P_W = DS_X_W + DS_M_W;
  localparam int unsigned     V_W    = 23;

  // Hours: centiseconds / 360000
  localparam longint unsigned HR_DIV = 360000;
  localparam int unsigned     HR_SH  = 43;
  localparam int unsigned     HR_M_W = 25;
  localparam logic [HR_M_W-1:0] HR_M =
    HR_M_W'(((64'd1 << HR_SH) + HR_DIV - 64'd1) / HR_DIV);
  localparam int unsigned     HR_P_W = U_W + HR_M_W;
  localparam int unsigned     HQ_W   = 6;
  localparam int unsigned     UREM_W = 19;

  // RA minutes: remainder / 6000
  localparam longint unsigned RM_DIV = 6000;
  localparam int unsigned     RM_SH  = 32;
  localparam int unsigned     RM_M_W = 20;
  localparam logic [RM_M_W-1:0] RM_M =
    RM_M_W'(((64'd1 << RM_SH) + RM_DIV - 64'd1) / RM_DIV);
  localparam int unsigned     RM_P_W = UREM_W + RM_M_W;

  // Degrees: deciseconds / 36000
  localparam longint unsigned DG_DIV = 36000;
  localparam int unsigned     DG_SH  = 39;
  localparam int unsigned     DG_M_W = 24;
  localparam logic [DG_M_W-1:0] DG_M =
    DG_M_W'(((64'd1 << DG_SH) + DG_DIV - 64'd1) / DG_DIV);
  localparam int unsigned     DG_P_W = V_W + DG_M_W;
  localparam int unsigned     DQ_W   = 8;
  localparam int unsigned     VREM_W = 16;

  // Declination minutes: remainder / 600
  localparam longint unsigned DM_DIV = 600;
  localparam int unsigned     DM_SH  = 26;
  localparam int unsigned     DM_M_W = 17;
  localparam logic [DM_M_W-1:0] DM_M =
    DM_M_W'(((64'd1 << DM_SH) + DM_DIV - 64'd1) / DM_DIV);
  localparam int unsigned     DM_P_W = VREM_W + DM_M_W;
  localparam int unsigned     DMQ_W  = 6;
  localparam int unsigned     DSM_W  = 10;

endpackage

@@ rtl/star_record_box_filter_core.sv @@
// Top level: record pipeline, window test and sexagesimal split of catalog star records.
// Takes one star record per cycle while in_ready_o is high and returns it, split into RA
// hours/minutes/centiseconds and signed declination degrees/minutes/deciseconds, when it
// lies inside the RA, declination and J magnitude windows; a record outside any window is
// dropped. An accepted record lands in an input register, passes four stages that each
// do one reciprocal multiply or one quotient-times-divisor subtract per coordinate, and
// reaches the result register. Every stage moves on as soon as the one after it is free,
// so a stalled result holds only the stages behind it. Window registers are written
// through the configuration port, one index per register, always ready.
module star_record_box_filter_core import srbf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,

  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [RA_W-1:0]         ra_micro_i,
  input  logic signed [DEC_W-1:0] dec_micro_i,
  input  logic signed [MAG_W-1:0] j_mag_i,
  input  logic signed [MAG_W-1:0] h_mag_i,
  input  logic signed [MAG_W-1:0] k_mag_i,
  input  logic [ERR_W-1:0]        mag_errors_i,
  input  logic [DATE_W-1:0]       obs_date_i,

  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [RA_W-1:0]          ra_out_o,
  output logic signed [DEC_W-1:0]  dec_out_o,
  output logic [HOURS_W-1:0]       ra_hours_o,
  output logic [RMIN_W-1:0]        ra_minutes_o,
  output logic [RCS_W-1:0]         ra_centiseconds_o,
  output logic signed [DEG_W-1:0]  dec_degrees_o,
  output logic signed [DMIN_W-1:0] dec_minutes_o,
  output logic signed [DSEC_W-1:0] dec_deciseconds_o,
  output logic signed [MAG_W-1:0]  j_mag_out_o,
  output logic [HK_W-1:0]          hk_mags_o,
  output logic [ERR_W-1:0]         errors_out_o,
  output logic [DATE_W-1:0]        date_out_o
);

  cfg_t              cfg;
  logic              pass;
  logic [NSTG-1:0]   valid_q, valid_d;
  logic [NSTG-1:0]   stage_rdy;
  rec_t              rec_q [NSTG];

  srbf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Test the record held in the input register
  srbf_window u_window (
    .cfg_i   (cfg),
    .ra_i    (rec_q[0].ra),
    .dec_i   ($signed(rec_q[0].dec)),
    .j_mag_i ($signed(rec_q[0].j_mag)),
    .pass_o  (pass)
  );

  // A stage may load when it is empty or its contents move on
  always_comb begin
    stage_rdy[NSTG-1] = !valid_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  assign in_ready_o = stage_rdy[0];

  // Advance valid flags; drop records that fail the window test
  always_comb begin
    valid_d = valid_q;
    if (stage_rdy[0]) begin
      valid_d[0] = in_valid_i;
    end
    if (stage_rdy[1]) begin
      valid_d[1] = valid_q[0] && pass;
    end
    for (int k = 2; k < NSTG; k++) begin
      if (stage_rdy[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Carry the raw record alongside the split arithmetic
  always_ff @(posedge clk_i) begin
    if (stage_rdy[0]) begin
      rec_q[0].ra     <= ra_micro_i;
      rec_q[0].dec    <= dec_micro_i;
      rec_q[0].j_mag  <= j_mag_i;
      rec_q[0].h_mag  <= h_mag_i;
      rec_q[0].k_mag  <= k_mag_i;
      rec_q[0].errors <= mag_errors_i;
      rec_q[0].date   <= obs_date_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (stage_rdy[k]) begin
        rec_q[k] <= rec_q[k-1];
      end
    end
  end

  srbf_ra_split u_ra_split (
    .clk_i             (clk_i),
    .en_i              (stage_rdy[NSTG-1:1]),
    .ra_i              (rec_q[0].ra),
    .ra_hours_o        (ra_hours_o),
    .ra_minutes_o      (ra_minutes_o),
    .ra_centiseconds_o (ra_centiseconds_o)
  );

  srbf_dec_split u_dec_split (
    .clk_i             (clk_i),
    .en_i              (stage_rdy[NSTG-1:1]),
    .dec_i             (rec_q[0].dec),
    .dec_degrees_o     (dec_degrees_o),
    .dec_minutes_o     (dec_minutes_o),
    .dec_deciseconds_o (dec_deciseconds_o)
  );

  // Result register
  assign out_valid_o  = valid_q[NSTG-1];
  assign ra_out_o     = rec_q[NSTG-1].ra;
  assign dec_out_o    = rec_q[NSTG-1].dec;
  assign j_mag_out_o  = rec_q[NSTG-1].j_mag;
  assign hk_mags_o    = {rec_q[NSTG-1].k_mag, rec_q[NSTG-1].h_mag};
  assign errors_out_o = rec_q[NSTG-1].errors;
  assign date_out_o   = rec_q[NSTG-1].date;

  // A full pipeline with a stalled result takes no new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&valid_q) && !out_ready_i) |-> !in_ready_o)
    else $error("request taken while pipeline is full and stalled");

  // RA minute and centisecond parts and declination deciseconds stay inside their unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ra_minutes_o <= RMIN_W'(59)) && (ra_centiseconds_o <= RCS_W'(5999))
                    && (dec_deciseconds_o <= 11'sd599) && (dec_deciseconds_o >= -11'sd599))
    else $error("sexagesimal split out of range");

  // Sub-degree parts of a negative declination are never positive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dec_out_o[DEC_W-1]) |-> (dec_minutes_o <= 7'sd0)
                                            && (dec_deciseconds_o <= 11'sd0))
    else $error("declination parts lost the sign");

endmodule

@@ rtl/srbf_cfg_regs.sv @@
// Window configuration registers with their reset values.
module srbf_cfg_regs import srbf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Always take a write request
  assign cfg_ready_o = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RA_LOW:     cfg_d.ra_low     = cfg_data_i[RA_W-1:0];
        CFG_RA_HIGH:    cfg_d.ra_high    = cfg_data_i[RA_W-1:0];
        CFG_WRAPS_ZERO: cfg_d.wraps_zero = cfg_data_i[0];
        CFG_DEC_LOW:    cfg_d.dec_low    = cfg_data_i[DEC_W-1:0];
        CFG_DEC_HIGH:   cfg_d.dec_high   = cfg_data_i[DEC_W-1:0];
        CFG_MAG_LOW:    cfg_d.mag_low    = cfg_data_i[CMAG_W-1:0];
        CFG_MAG_HIGH:   cfg_d.mag_high   = cfg_data_i[CMAG_W-1:0];
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ra_low     <= RA_LOW_RST;
      cfg_q.ra_high    <= RA_HIGH_RST;
      cfg_q.wraps_zero <= 1'b0;
      cfg_q.dec_low    <= DEC_LOW_RST;
      cfg_q.dec_high   <= DEC_HIGH_RST;
      cfg_q.mag_low    <= MAG_LOW_RST;
      cfg_q.mag_high   <= MAG_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/srbf_window.sv @@
// Box test of one record against the RA, declination and J magnitude windows.
module srbf_window import srbf_pkg::*; (
  input  cfg_t                    cfg_i,
  input  logic [RA_W-1:0]         ra_i,
  input  logic signed [DEC_W-1:0] dec_i,
  input  logic signed [MAG_W-1:0] j_mag_i,
  output logic                    pass_o
);

  logic                     ra_ge;
  logic                     ra_le;
  logic                     ra_ok;
  logic                     dec_ok;
  logic                     mag_ok;
  logic signed [CMAG_W-1:0] j_ext;

  // RA: plain interval, or union of the two halves across zero
  assign ra_ge = (ra_i >= cfg_i.ra_low);
  assign ra_le = (ra_i <= cfg_i.ra_high);
  assign ra_ok = cfg_i.wraps_zero ? (ra_ge || ra_le) : (ra_ge && ra_le);

  // Declination window, inclusive bounds
  assign dec_ok = (dec_i >= cfg_i.dec_low) && (dec_i <= cfg_i.dec_high);

  // Sign-extend J to the bound width before comparing
  assign j_ext  = {{(CMAG_W - MAG_W){j_mag_i[MAG_W-1]}}, j_mag_i};
  assign mag_ok = (j_ext >= cfg_i.mag_low) && (j_ext <= cfg_i.mag_high);

  assign pass_o = ra_ok && dec_ok && mag_ok;

endmodule

@@ rtl/srbf_ra_split.sv @@
// RA to hours, minutes and centiseconds of time over five register stages.
module srbf_ra_split import srbf_pkg::*; (
  input  logic                 clk_i,
  input  logic [NSTG-1:1]      en_i,
  input  logic [RA_W-1:0]      ra_i,
  output logic [HOURS_W-1:0]   ra_hours_o,
  output logic [RMIN_W-1:0]    ra_minutes_o,
  output logic [RCS_W-1:0]     ra_centiseconds_o
);

  logic [CS_X_W-1:0]  x3;
  logic [CS_P_W-1:0]  cs_prod;
  logic [HR_P_W-1:0]  hr_prod;
  logic [RM_P_W-1:0]  rm_prod;

  logic [U_W-1:0]     u1_q, u2_q;
  logic [HQ_W-1:0]    hq2_q, hq3_q, hq4_q;
  logic [UREM_W-1:0]  urem3_q, urem4_q;
  logic [RMIN_W-1:0]  mq4_q;
  logic [HOURS_W-1:0] hours_q;
  logic [RMIN_W-1:0]  minutes_q;
  logic [RCS_W-1:0]   centis_q;

  // Total centiseconds of time: 3 * ra / 125 by reciprocal
  assign x3      = CS_X_W'(ra_i) + CS_X_W'({ra_i, 1'b0});
  assign cs_prod = CS_P_W'(x3) * CS_P_W'(CS_M);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      u1_q <= cs_prod[CS_SH +: U_W];
    end
  end

  // Hour quotient
  assign hr_prod = HR_P_W'(u1_q) * HR_P_W'(HR_M);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      hq2_q <= hr_prod[HR_SH +: HQ_W];
      u2_q  <= u1_q;
    end
  end

  // Centiseconds left within the hour
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      urem3_q <= UREM_W'(u2_q - U_W'(U_W'(hq2_q) * U_W'(HR_DIV)));
      hq3_q   <= hq2_q;
    end
  end

  // Minute quotient
  assign rm_prod = RM_P_W'(urem3_q) * RM_P_W'(RM_M);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      mq4_q   <= rm_prod[RM_SH +: RMIN_W];
      urem4_q <= urem3_q;
      hq4_q   <= hq3_q;
    end
  end

  // Final split, hours reduced to field width
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      hours_q   <= hq4_q[HOURS_W-1:0];
      minutes_q <= mq4_q;
      centis_q  <= RCS_W'(urem4_q - UREM_W'(UREM_W'(mq4_q) * UREM_W'(RM_DIV)));
    end
  end

  assign ra_hours_o        = hours_q;
  assign ra_minutes_o      = minutes_q;
  assign ra_centiseconds_o = centis_q;

endmodule

@@ rtl/srbf_dec_split.sv @@
// Declination to signed degrees, arc minutes and arc deciseconds over five register stages.
module srbf_dec_split import srbf_pkg::*; (
  input  logic               clk_i,
  input  logic [NSTG-1:1]    en_i,
  input  logic [DEC_W-1:0]   dec_i,
  output logic [DEG_W-1:0]   dec_degrees_o,
  output logic [DMIN_W-1:0]  dec_minutes_o,
  output logic [DSEC_W-1:0]  dec_deciseconds_o
);

  logic [DEC_W-1:0]  mag;
  logic [DS_X_W-1:0] x9;
  logic [DS_P_W-1:0] ds_prod;
  logic [DG_P_W-1:0] dg_prod;
  logic [DM_P_W-1:0] dm_prod;

  logic [V_W-1:0]    v1_q, v2_q;
  logic [DQ_W-1:0]   dq2_q, dq3_q, dq4_q;
  logic [VREM_W-1:0] vrem3_q, vrem4_q;
  logic [DMQ_W-1:0]  dm4_q;
  logic              neg1_q, neg2_q, neg3_q, neg4_q;
  logic [DEG_W-1:0]  deg_q;
  logic [DMIN_W-1:0] min_q;
  logic [DSEC_W-1:0] dsec_q;
  logic [DSEC_W-1:0] dsec_mag;

  // Work on the magnitude; every part takes the sign of the declination
  assign mag     = dec_i[DEC_W-1] ? DEC_W'(-dec_i) : dec_i;
  assign x9      = DS_X_W'({mag, 3'b000}) + DS_X_W'(mag);
  assign ds_prod = DS_P_W'(x9) * DS_P_W'(DS_M);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      v1_q   <= ds_prod[DS_SH +: V_W];
      neg1_q <= dec_i[DEC_W-1];
    end
  end

  // Degree quotient
  assign dg_prod = DG_P_W'(v1_q) * DG_P_W'(DG_M);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dq2_q  <= dg_prod[DG_SH +: DQ_W];
      v2_q   <= v1_q;
      neg2_q <= neg1_q;
    end
  end

  // Deciseconds left within the degree
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      vrem3_q <= VREM_W'(v2_q - V_W'(V_W'(dq2_q) * V_W'(DG_DIV)));
      dq3_q   <= dq2_q;
      neg3_q  <= neg2_q;
    end
  end

  // Arc minute quotient
  assign dm_prod = DM_P_W'(vrem3_q) * DM_P_W'(DM_M);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      dm4_q   <= dm_prod[DM_SH +: DMQ_W];
      vrem4_q <= vrem3_q;
      dq4_q   <= dq3_q;
      neg4_q  <= neg3_q;
    end
  end

  assign dsec_mag = DSEC_W'(DSM_W'(vrem4_q - VREM_W'(VREM_W'(dm4_q) * VREM_W'(DM_DIV))));

  // Apply the sign and reduce to field widths
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      deg_q  <= neg4_q ? DEG_W'(DEG_W'(0) - DEG_W'(dq4_q)) : DEG_W'(dq4_q);
      min_q  <= neg4_q ? DMIN_W'(DMIN_W'(0) - DMIN_W'(dm4_q)) : DMIN_W'(dm4_q);
      dsec_q <= neg4_q ? DSEC_W'(DSEC_W'(0) - dsec_mag) : dsec_mag;
    end
  end

  assign dec_degrees_o     = deg_q;
  assign dec_minutes_o     = min_q;
  assign dec_deciseconds_o = dsec_q;

endmodule
